FILE: rtl/pata_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and result builders for primitive assembly
package pata_pkg;

  localparam int unsigned IndexWidth = 16;
  localparam int unsigned InIdxW     = 16;
  localparam int unsigned ResIdxW    = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [ResIdxW-1:0] IdxMask =
    (IndexWidth >= ResIdxW) ? '1 : ResIdxW'((64'd1 << IndexWidth) - 64'd1);

  localparam logic [15:0] SecondUvFlag   = 16'h2000;
  localparam logic [1:0]  SecondUvSource = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_OFFSET = 2'd0,
    CFG_NRM_OFFSET = 2'd1,
    CFG_TEX_OFFSET = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_LINES     = 3'd0,
    KIND_LINE_STRIP = 3'd1,
    KIND_TRIANGLES = 3'd2,
    KIND_TRI_STRIP = 3'd3,
    KIND_FAN       = 3'd4,
    KIND_QUADS     = 3'd5,
    KIND_OTHER     = 3'd6
  } prim_kind_e;

  typedef enum logic [1:0] {
    OUT_LINE  = 2'd0,
    OUT_TRI   = 2'd1,
    OUT_POINT = 2'd2
  } out_kind_e;

  typedef struct packed {
    logic [ResIdxW-1:0] pos;
    logic [ResIdxW-1:0] uv;
    logic [ResIdxW-1:0] nrm;
  } vert_t;

  typedef struct packed {
    out_kind_e kind;
    vert_t     a;
    vert_t     b;
    vert_t     c;
  } res_t;

  // a job holds the one or two results of one accepted vertex
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_t mk_line(vert_t a, vert_t b);
    res_t r;
    r       = '0;
    r.kind  = OUT_LINE;
    r.a.pos = a.pos;
    r.a.uv  = a.uv;
    r.b.pos = b.pos;
    r.b.uv  = b.uv;
    return r;
  endfunction

  function automatic res_t mk_tri(vert_t a, vert_t b, vert_t c);
    res_t r;
    r.kind = OUT_TRI;
    r.a    = a;
    r.b    = b;
    r.c    = c;
    return r;
  endfunction

  function automatic res_t mk_point(logic [ResIdxW-1:0] pos);
    res_t r;
    r       = '0;
    r.kind  = OUT_POINT;
    r.a.pos = pos;
    r.b.pos = pos;
    r.c.pos = pos;
    return r;
  endfunction

endpackage

FILE: rtl/pata_if.sv
`timescale 1ns / 1ps
// vertex and result channel interfaces
interface pata_vtx_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   prim_kind;
  logic                         first_vertex;
  logic [pata_pkg::InIdxW-1:0]  position_index;
  logic [pata_pkg::InIdxW-1:0]  normal_index;
  logic [pata_pkg::InIdxW-1:0]  texcoord0_index;
  logic [pata_pkg::InIdxW-1:0]  texcoord1_index;
  logic [15:0]                  material_flags;
  logic [1:0]                   uv_source;

  modport source (
    output valid, prim_kind, first_vertex, position_index, normal_index,
           texcoord0_index, texcoord1_index, material_flags, uv_source,
    input  ready
  );
  modport sink (
    input  valid, prim_kind, first_vertex, position_index, normal_index,
           texcoord0_index, texcoord1_index, material_flags, uv_source,
    output ready
  );
endinterface

interface pata_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   out_kind;
  logic [pata_pkg::ResIdxW-1:0] pos_a;
  logic [pata_pkg::ResIdxW-1:0] uv_a;
  logic [pata_pkg::ResIdxW-1:0] nrm_a;
  logic [pata_pkg::ResIdxW-1:0] pos_b;
  logic [pata_pkg::ResIdxW-1:0] uv_b;
  logic [pata_pkg::ResIdxW-1:0] nrm_b;
  logic [pata_pkg::ResIdxW-1:0] pos_c;
  logic [pata_pkg::ResIdxW-1:0] uv_c;
  logic [pata_pkg::ResIdxW-1:0] nrm_c;
  logic                         last_of_run;

  modport source (
    output valid, out_kind, pos_a, uv_a, nrm_a, pos_b, uv_b, nrm_b,
           pos_c, uv_c, nrm_c, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_kind, pos_a, uv_a, nrm_a, pos_b, uv_b, nrm_b,
           pos_c, uv_c, nrm_c, last_of_run,
    output ready
  );
endinterface

FILE: rtl/pata_front.sv
`timescale 1ns / 1ps
// front end: index resolve, vertex history and primitive classification
module pata_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pata_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pata_pkg::ResIdxW-1:0]  cfg_data_i,
  pata_vtx_if.sink                      vtx_i,
  input  pata_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output pata_pkg::job_t                job_o
);
  import pata_pkg::*;

  logic [ResIdxW-1:0] pos_off_q, nrm_off_q, tex_off_q;
  logic [ResIdxW-1:0] cnt_q, cnt_d, idx;
  logic [1:0]         m3_q, m3_d, idx_m3;
  vert_t              anchor_q, p0_q, p1_q, p2_q, cur;
  logic               accept, has_res, second_uv;
  logic [ResIdxW-1:0] tex_raw;

  assign vtx_i.ready = !q_stat_i.full;
  assign accept      = vtx_i.valid && vtx_i.ready;
  assign push_o      = accept && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_off_q <= '0;
      nrm_off_q <= '0;
      tex_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POS_OFFSET: pos_off_q <= cfg_data_i;
        CFG_NRM_OFFSET: nrm_off_q <= cfg_data_i;
        CFG_TEX_OFFSET: tex_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    idx       = vtx_i.first_vertex ? '0 : cnt_q;
    idx_m3    = vtx_i.first_vertex ? 2'd0 : m3_q;
    second_uv = ((vtx_i.material_flags & SecondUvFlag) != '0) ||
                (vtx_i.uv_source == SecondUvSource);
    tex_raw   = second_uv ? ResIdxW'(vtx_i.texcoord1_index)
                          : ResIdxW'(vtx_i.texcoord0_index);
    cur.pos   = (ResIdxW'(vtx_i.position_index) & IdxMask) + pos_off_q;
    cur.nrm   = (ResIdxW'(vtx_i.normal_index) & IdxMask) + nrm_off_q;
    cur.uv    = (tex_raw & IdxMask) + tex_off_q;

    cnt_d = idx + ResIdxW'(1);
    // i mod 3 restarts when the counter wraps
    if (idx == '1 || idx_m3 == 2'd2) begin
      m3_d = 2'd0;
    end else begin
      m3_d = idx_m3 + 2'd1;
    end

    has_res = 1'b0;
    job_o   = '0;
    case (prim_kind_e'(vtx_i.prim_kind))
      KIND_LINES: begin
        if (idx[0]) begin
          has_res  = 1'b1;
          job_o.r0 = mk_line(p0_q, cur);
        end
      end
      KIND_LINE_STRIP: begin
        if (idx != '0) begin
          has_res  = 1'b1;
          job_o.r0 = mk_line(p0_q, cur);
        end
      end
      KIND_TRIANGLES: begin
        if (idx_m3 == 2'd2) begin
          has_res  = 1'b1;
          job_o.r0 = mk_tri(p1_q, p0_q, cur);
        end
      end
      KIND_TRI_STRIP: begin
        if (idx[ResIdxW-1:1] != '0) begin
          has_res  = 1'b1;
          // odd positions swap winding
          job_o.r0 = idx[0] ? mk_tri(p1_q, cur, p0_q) : mk_tri(p1_q, p0_q, cur);
        end
      end
      KIND_FAN: begin
        if (idx[ResIdxW-1:1] != '0) begin
          has_res  = 1'b1;
          job_o.r0 = mk_tri(anchor_q, p0_q, cur);
        end
      end
      KIND_QUADS: begin
        if (idx[1:0] == 2'b11) begin
          has_res   = 1'b1;
          job_o.two = 1'b1;
          job_o.r0  = mk_tri(p2_q, p1_q, p0_q);
          job_o.r1  = mk_tri(p2_q, p0_q, cur);
        end
      end
      default: begin
        has_res  = 1'b1;
        job_o.r0 = mk_point(cur.pos);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      m3_q     <= '0;
      anchor_q <= '0;
      p0_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      m3_q  <= m3_d;
      if (idx == '0) begin
        anchor_q <= cur;
      end
      p2_q <= p1_q;
      p1_q <= p0_q;
      p0_q <= cur;
    end
  end

endmodule

FILE: rtl/pata_queue.sv
`timescale 1ns / 1ps
// short job queue between front and back
module pata_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pata_pkg::job_t     job_i,
  input  logic               pop_i,
  output pata_pkg::job_t     head_o,
  output pata_pkg::q_stat_t  stat_o
);
  import pata_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

FILE: rtl/pata_back.sv
`timescale 1ns / 1ps
// back end: unpacks jobs into result words behind an output register
module pata_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pata_pkg::job_t     head_i,
  input  pata_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  pata_res_if.source         res_o
);
  import pata_pkg::*;

  logic valid_q, last_q, sel_q, sel_d, load;
  res_t res_q;

  assign load  = !q_stat_i.empty && (!valid_q || res_o.ready);
  // the job leaves once its final result is loaded
  assign pop_o = load && (!head_i.two || sel_q);

  always_comb begin
    sel_d = sel_q;
    if (pop_o) begin
      sel_d = 1'b0;
    end else if (load) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= sel_q ? head_i.r1 : head_i.r0;
      last_q <= !head_i.two || sel_q;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.out_kind    = res_q.kind;
  assign res_o.pos_a       = res_q.a.pos;
  assign res_o.uv_a        = res_q.a.uv;
  assign res_o.nrm_a       = res_q.a.nrm;
  assign res_o.pos_b       = res_q.b.pos;
  assign res_o.uv_b        = res_q.b.uv;
  assign res_o.nrm_b       = res_q.b.nrm;
  assign res_o.pos_c       = res_q.c.pos;
  assign res_o.uv_c        = res_q.c.uv;
  assign res_o.nrm_c       = res_q.c.nrm;
  assign res_o.last_of_run = last_q;

endmodule

FILE: rtl/primitive_assembly_to_triangles.sv
`timescale 1ns / 1ps
// primitive assembly top level: vertex words in, line/triangle/point words out
//
// vtx_i carries one vertex word per accepted valid/ready handshake; tri_o
// carries result words (lines, triangles or degenerate points), with
// last_of_run set on the final word caused by a vertex. quad-closing vertices
// give two words, vertices that close nothing give none. a result word is
// written into the job queue at the edge that accepts its vertex, then loaded
// into the output register by the back end. throughput: one vertex per cycle,
// one result word per cycle, while the receiver takes words and the queue has
// room; the two words of a quad leave in turn. the offsets are written through
// cfg_we_i/cfg_idx_i/cfg_data_i (0 position, 1 normal, 2 texture); the user
// must write them only while no vertex is in flight, the block does not enforce
// it; other indices are ignored. reset clears offsets, the vertex counter, the
// vertex history and the queue. when the receiver stalls the output word holds,
// the two-entry job queue fills and vtx_i.ready drops until room frees up.
module primitive_assembly_to_triangles (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pata_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pata_pkg::ResIdxW-1:0]  cfg_data_i,
  pata_vtx_if.sink                      vtx_i,
  pata_res_if.source                    tri_o
);
  import pata_pkg::*;

  job_t    job, head;
  q_stat_t q_stat;
  logic    push, pop;

  pata_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vtx_i      (vtx_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job)
  );

  pata_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  pata_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res_o    (tri_o)
  );

endmodule
